// ----- hdl/msp_pkg.sv -----
package msp_pkg;

  // Largest whole frame, header and check byte included, that is parsed.
  localparam int unsigned MAX_FRAME = 1024;
  localparam int unsigned TOTAL_W   = 17;
  localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_FRAME);

  // Framing overhead: '$', version, direction, header bytes and check byte.
  localparam logic [TOTAL_W-1:0] V1_OVERHEAD = TOTAL_W'(6);
  localparam logic [TOTAL_W-1:0] V2_OVERHEAD = TOTAL_W'(9);

  // Framing characters.
  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_V1    = 8'h4D;  // 'M'
  localparam logic [7:0] CHAR_V2    = 8'h58;  // 'X'
  localparam logic [7:0] DIR_RESET  = 8'h3E;  // '>'

  // CRC-8/DVB-S2 polynomial.
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Parser phase codes.
  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_VER   = 4'd1;
  localparam logic [3:0] PH_DIR   = 4'd2;
  localparam logic [3:0] PH_SIZE1 = 4'd3;
  localparam logic [3:0] PH_CMD1  = 4'd4;
  localparam logic [3:0] PH_FLAG2 = 4'd5;
  localparam logic [3:0] PH_IDLO  = 4'd6;
  localparam logic [3:0] PH_IDHI  = 4'd7;
  localparam logic [3:0] PH_LENLO = 4'd8;
  localparam logic [3:0] PH_LENHI = 4'd9;
  localparam logic [3:0] PH_PAY   = 4'd10;
  localparam logic [3:0] PH_CHECK = 4'd11;

  // Result kinds and verdicts.
  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_END     = 1'b1;
  localparam logic [1:0] VERDICT_GOOD     = 2'd0;
  localparam logic [1:0] VERDICT_BAD      = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        version;
    logic [7:0]  frame_flag;
    logic [15:0] message_id;
    logic [15:0] payload_length;
    logic [1:0]  verdict;
  } res_t;

  // One byte step of CRC-8/DVB-S2, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/msp_frame_parser.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_stall  | rx_byte
// output   | out_valid / out_stall| kind, payload_byte, version, frame_flag,
//          |                      | message_id, payload_length, verdict
// config   | cfg_write            | cfg_data (expected direction character)
//
// One byte is taken every cycle while in_stall is low; its result, if any, goes to
// the output register, or to the skid register if that is stalled. Parse state and
// checksum update in the transfer's cycle: one parallel CRC-8 step (v2) or XOR (v1).
// A two-entry output stage (output register plus skid register) lets input
// keep flowing while one result waits; in_stall rises only once both hold data.
// Synchronous reset returns the parser to hunting for '$' and empties the
// output stage; the direction register resets to '>'.
module msp_frame_parser
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic        version,
  output logic [7:0]  frame_flag,
  output logic [15:0] message_id,
  output logic [15:0] payload_length,
  output logic [1:0]  verdict
);

  logic [7:0]  expected_direction;
  logic [3:0]  phase, phase_next;
  logic [15:0] byte_index, byte_index_next;
  logic        frame_version, frame_version_next;
  logic [7:0]  flag_store, flag_store_next;
  logic [15:0] id_store, id_store_next;
  logic [15:0] length_store, length_store_next;
  logic [7:0]  running_check, running_check_next;

  logic        in_xfer;
  logic        res_valid;
  res_t        res;
  logic        emit_kind;
  logic [7:0]  emit_byte;
  logic [1:0]  emit_verdict;
  logic [7:0]  check_absorbed;
  logic [15:0] hdr_length;
  logic [TOTAL_W-1:0] frame_total;
  logic        too_long;

  logic        out_valid_r;
  res_t        out_res;
  logic        skid_valid;
  res_t        skid_res;
  logic        out_free;

  // Direction character register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_direction <= DIR_RESET;
    end else if (cfg_write) begin
      expected_direction <= cfg_data;
    end
  end

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;

  // The received byte folded into the running check for the current version.
  assign check_absorbed = frame_version ? crc8_step(running_check, rx_byte)
                                        : (running_check ^ rx_byte);

  // Length as it stands once the header is complete, and the whole frame size.
  assign hdr_length  = (phase == PH_LENHI) ? {rx_byte, length_store[7:0]} : length_store;
  assign frame_total = {1'b0, hdr_length} + (frame_version ? V2_OVERHEAD : V1_OVERHEAD);
  assign too_long    = frame_total > MAX_TOTAL;

  // Parser next state and result.
  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    frame_version_next = frame_version;
    flag_store_next    = flag_store;
    id_store_next      = id_store;
    length_store_next  = length_store;
    running_check_next = running_check;
    res_valid          = 1'b0;
    emit_kind          = KIND_PAYLOAD;
    emit_byte          = 8'd0;
    emit_verdict       = VERDICT_GOOD;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == CHAR_START) begin
          phase_next         = PH_VER;
          byte_index_next    = 16'd0;
          frame_version_next = 1'b0;
          flag_store_next    = 8'd0;
          id_store_next      = 16'd0;
          length_store_next  = 16'd0;
          running_check_next = 8'd0;
        end
      end
      PH_VER: begin
        if (rx_byte == CHAR_V2) begin
          frame_version_next = 1'b1;
          phase_next         = PH_DIR;
        end else if (rx_byte == CHAR_V1) begin
          frame_version_next = 1'b0;
          phase_next         = PH_DIR;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_DIR: begin
        if (rx_byte == expected_direction) begin
          phase_next = frame_version ? PH_FLAG2 : PH_SIZE1;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_SIZE1: begin
        length_store_next  = {8'd0, rx_byte};
        running_check_next = check_absorbed;
        phase_next         = PH_CMD1;
      end
      PH_FLAG2: begin
        flag_store_next    = rx_byte;
        running_check_next = check_absorbed;
        phase_next         = PH_IDLO;
      end
      PH_IDLO: begin
        id_store_next      = {8'd0, rx_byte};
        running_check_next = check_absorbed;
        phase_next         = PH_IDHI;
      end
      PH_IDHI: begin
        id_store_next      = {rx_byte, id_store[7:0]};
        running_check_next = check_absorbed;
        phase_next         = PH_LENLO;
      end
      PH_LENLO: begin
        length_store_next  = {8'd0, rx_byte};
        running_check_next = check_absorbed;
        phase_next         = PH_LENHI;
      end
      PH_CMD1, PH_LENHI: begin
        // Header complete: abort oversized frames, else go to payload or check.
        if (phase == PH_CMD1) begin
          id_store_next = {8'd0, rx_byte};
        end else begin
          length_store_next = hdr_length;
        end
        running_check_next = check_absorbed;
        byte_index_next    = 16'd0;
        if (too_long) begin
          res_valid    = 1'b1;
          emit_kind    = KIND_END;
          emit_verdict = VERDICT_OVERFLOW;
          phase_next   = PH_HUNT;
        end else if (hdr_length != 16'd0) begin
          phase_next = PH_PAY;
        end else begin
          phase_next = PH_CHECK;
        end
      end
      PH_PAY: begin
        running_check_next = check_absorbed;
        byte_index_next    = byte_index + 16'd1;
        if (byte_index_next >= length_store) begin
          phase_next = PH_CHECK;
        end
        res_valid = 1'b1;
        emit_byte = rx_byte;
      end
      PH_CHECK: begin
        phase_next   = PH_HUNT;
        res_valid    = 1'b1;
        emit_kind    = KIND_END;
        emit_verdict = (running_check == rx_byte) ? VERDICT_GOOD : VERDICT_BAD;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    res.kind           = emit_kind;
    res.payload_byte   = emit_byte;
    res.version        = frame_version_next;
    res.frame_flag     = flag_store_next;
    res.message_id     = id_store_next;
    res.payload_length = length_store_next;
    res.verdict        = emit_verdict;
  end

  // Parser state registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_index    <= 16'd0;
      frame_version <= 1'b0;
      flag_store    <= 8'd0;
      id_store      <= 16'd0;
      length_store  <= 16'd0;
      running_check <= 8'd0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      frame_version <= frame_version_next;
      flag_store    <= flag_store_next;
      id_store      <= id_store_next;
      length_store  <= length_store_next;
      running_check <= running_check_next;
    end
  end

  // Output register with a skid register behind it.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid_r <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        out_valid_r <= in_xfer && res_valid;
      end
    end else if (in_xfer && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && in_xfer && res_valid) begin
      skid_res <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign kind           = out_res.kind;
  assign payload_byte   = out_res.payload_byte;
  assign version        = out_res.version;
  assign frame_flag     = out_res.frame_flag;
  assign message_id     = out_res.message_id;
  assign payload_length = out_res.payload_length;
  assign verdict        = out_res.verdict;

endmodule

// ----- hdl/msp_chk.sv -----
module msp_chk
  import msp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic [7:0]  cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [7:0]  payload_byte,
  input logic        version,
  input logic [7:0]  frame_flag,
  input logic [15:0] message_id,
  input logic [15:0] payload_length,
  input logic [1:0]  verdict
);

  // A stalled result is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte)
      && $stable(message_id) && $stable(payload_length) && $stable(verdict))
    else $error("stalled result changed");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A forwarded payload byte carries a good verdict; a frame end carries no byte.
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_PAYLOAD && verdict == VERDICT_GOOD)
      || (kind == KIND_END && payload_byte == 8'd0 && verdict != 2'd3))
    else $error("result fields disagree with kind");

  // A v1 frame has no flag, only an 8-bit command and only an 8-bit length.
  a_v1_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !version |-> frame_flag == 8'd0 && message_id[15:8] == 8'd0
      && payload_length[15:8] == 8'd0)
    else $error("v1 result carries v2-only fields");

endmodule

bind msp_frame_parser msp_chk u_msp_chk (.*);

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 200000;

  // Tracks the parser state and holds the results that are due, oldest first.
  class msp_frame_tracker;
    logic [7:0]  direction;
    logic [3:0]  phase;
    logic [15:0] pay_count;
    logic        is_v2;
    logic [7:0]  flag;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  check;
    res_t        results_due[$];
    int          mismatches;

    function new();
      direction  = DIR_RESET;
      phase      = PH_HUNT;
      pay_count  = 16'h0000;
      is_v2      = 1'b0;
      flag       = 8'h00;
      id         = 16'h0000;
      len        = 16'h0000;
      check      = 8'h00;
      mismatches = 0;
    endfunction

    // XOR sum for v1, CRC-8 with polynomial 0xD5 for v2.
    static function logic [7:0] chk_fold(bit v2, logic [7:0] acc, logic [7:0] b);
      logic [7:0] c;
      if (!v2) return acc ^ b;
      c = acc ^ b;
      repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
      return c;
    endfunction

    function void set_direction(logic [7:0] d);
      direction = d;
    endfunction

    function void queue_result(logic k, logic [7:0] pb, logic [1:0] v);
      res_t r;
      r.kind           = k;
      r.payload_byte   = pb;
      r.version        = is_v2;
      r.frame_flag     = flag;
      r.message_id     = id;
      r.payload_length = len;
      r.verdict        = v;
      results_due.push_back(r);
    endfunction

    // The header is complete: either abort an oversized frame or move on.
    function void close_header();
      logic [TOTAL_W-1:0] total;
      total     = {1'b0, len} + (is_v2 ? V2_OVERHEAD : V1_OVERHEAD);
      pay_count = 16'h0000;
      if (total > MAX_TOTAL) begin
        queue_result(KIND_END, 8'h00, VERDICT_OVERFLOW);
        phase = PH_HUNT;
      end else begin
        phase = (len != 16'h0000) ? PH_PAY : PH_CHECK;
      end
    endfunction

    // One accepted byte advances the parser and may make one result due.
    function void accept_byte(logic [7:0] b);
      case (phase)
        PH_HUNT: begin
          if (b == CHAR_START) begin
            phase     = PH_VER;
            pay_count = 16'h0000;
            is_v2     = 1'b0;
            flag      = 8'h00;
            id        = 16'h0000;
            len       = 16'h0000;
            check     = 8'h00;
          end
        end
        PH_VER: begin
          if (b == CHAR_V2) begin
            is_v2 = 1'b1;
            phase = PH_DIR;
          end else if (b == CHAR_V1) begin
            is_v2 = 1'b0;
            phase = PH_DIR;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_DIR: begin
          if (b == direction) phase = is_v2 ? PH_FLAG2 : PH_SIZE1;
          else phase = PH_HUNT;
        end
        PH_SIZE1: begin
          len   = {8'h00, b};
          check = chk_fold(is_v2, check, b);
          phase = PH_CMD1;
        end
        PH_CMD1: begin
          id    = {8'h00, b};
          check = chk_fold(is_v2, check, b);
          close_header();
        end
        PH_FLAG2: begin
          flag  = b;
          check = chk_fold(is_v2, check, b);
          phase = PH_IDLO;
        end
        PH_IDLO: begin
          id    = {8'h00, b};
          check = chk_fold(is_v2, check, b);
          phase = PH_IDHI;
        end
        PH_IDHI: begin
          id[15:8] = b;
          check    = chk_fold(is_v2, check, b);
          phase    = PH_LENLO;
        end
        PH_LENLO: begin
          len   = {8'h00, b};
          check = chk_fold(is_v2, check, b);
          phase = PH_LENHI;
        end
        PH_LENHI: begin
          len[15:8] = b;
          check     = chk_fold(is_v2, check, b);
          close_header();
        end
        PH_PAY: begin
          check     = chk_fold(is_v2, check, b);
          pay_count = pay_count + 16'd1;
          if (pay_count >= len) phase = PH_CHECK;
          queue_result(KIND_PAYLOAD, b, VERDICT_GOOD);
        end
        PH_CHECK: begin
          phase = PH_HUNT;
          queue_result(KIND_END, 8'h00, (check == b) ? VERDICT_GOOD : VERDICT_BAD);
        end
        default: begin
          phase = PH_HUNT;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    // Compares one accepted result with the oldest one that is due.
    function void match_result(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("version", 16'(want.version), 16'(got.version));
      compare_field("frame_flag", 16'(want.frame_flag), 16'(got.frame_flag));
      compare_field("message_id", want.message_id, got.message_id);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("verdict", 16'(want.verdict), 16'(got.verdict));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        version;
  logic [7:0]  frame_flag;
  logic [15:0] message_id;
  logic [15:0] payload_length;
  logic [1:0]  verdict;

  msp_frame_tracker sb;
  logic [7:0] stream_q[$];
  logic [7:0] gen_sum;
  bit         gaps_on = 1'b0;
  bit         hold_req = 1'b0;
  int         cycles = 0;

  msp_frame_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .version        (version),
    .frame_flag     (frame_flag),
    .message_id     (message_id),
    .payload_length (payload_length),
    .verdict        (verdict)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Observe both channels at each edge; a result never shares an edge with its byte.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        sb.match_result({kind, payload_byte, version, frame_flag, message_id,
                         payload_length, verdict});
      end
      if (in_valid && !in_stall) sb.accept_byte(rx_byte);
    end
  end

  // The receiver stalls on stretches of its own choosing, or holds off on request.
  initial begin : receiver
    int run;
    int pct;
    run = 0;
    pct = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (run == 0) begin
        run = $urandom_range(200, 20);
        case ($urandom_range(2))
          0: pct = 0;
          1: pct = 25;
          default: pct = 70;
        endcase
      end
      run--;
      out_stall <= ($urandom_range(99) < pct);
    end
  end

  function automatic void put_summed(bit v2, logic [7:0] b);
    stream_q.push_back(b);
    gen_sum = msp_frame_tracker::chk_fold(v2, gen_sum, b);
  endfunction

  // Appends one frame to the byte stream; v1 takes only the low byte of the length.
  function automatic void add_frame(bit v2, logic [7:0] dir, logic [15:0] len,
                                    logic [7:0] flag, logic [15:0] id, bit corrupt);
    gen_sum = 8'h00;
    stream_q.push_back(CHAR_START);
    stream_q.push_back(v2 ? CHAR_V2 : CHAR_V1);
    stream_q.push_back(dir);
    if (v2) begin
      put_summed(1'b1, flag);
      put_summed(1'b1, id[7:0]);
      put_summed(1'b1, id[15:8]);
      put_summed(1'b1, len[7:0]);
      put_summed(1'b1, len[15:8]);
    end else begin
      put_summed(1'b0, len[7:0]);
      put_summed(1'b0, id[7:0]);
    end
    // An oversized header ends the frame; nothing more belongs to it.
    if ({1'b0, len} + (v2 ? V2_OVERHEAD : V1_OVERHEAD) > MAX_TOTAL) return;
    repeat (len) put_summed(v2, 8'($urandom));
    stream_q.push_back(corrupt ? gen_sum ^ 8'($urandom_range(255, 1)) : gen_sum);
  endfunction

  // Mostly well-formed frames, with some line noise, wrong direction, bad checks and cut frames.
  function automatic int make_random_frame();
    bit          v2;
    logic [15:0] len;
    logic [7:0]  dir;
    int          pick;
    int          start;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1)) stream_q.push_back(8'($urandom));
    end
    start = stream_q.size();
    v2    = 1'($urandom_range(1));
    pick  = $urandom_range(99);
    if (pick < 10) len = 16'd0;
    else if (pick < 80) len = 16'($urandom_range(12, 1));
    else if (pick < 95) len = 16'($urandom_range(48, 13));
    else len = v2 ? 16'($urandom_range(65535, 1016)) : 16'($urandom_range(120, 49));
    dir = sb.direction;
    if ($urandom_range(19) == 0) dir = dir ^ 8'($urandom_range(255, 1));
    add_frame(v2, dir, len, 8'($urandom), 16'($urandom), $urandom_range(6) == 0);
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(stream_q.size() - start - 1, 1)) void'(stream_q.pop_back());
    end
    return stream_q.size() - start;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the queued bytes in bursts; gaps between bursts only when enabled.
  task automatic send_stream();
    int burst;
    burst = $urandom_range(16, 1);
    while (stream_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(16, 1);
        if (gaps_on) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(8, 1)) @(posedge clk);
        end
      end
      push_byte(stream_q.pop_front());
      burst--;
    end
  endtask

  // Stops sending and waits until every due result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_direction(input logic [7:0] d);
    cfg_write <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_direction(d);
  endtask

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      sent += make_random_frame();
      send_stream();
    end
  endtask

  initial begin : stimulus
    logic [7:0] dir_plan [5];
    sb = new();
    dir_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h3C, DIR_RESET};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset direction. A second start byte in the
    // version slot sends the parser back to hunting without starting a frame.
    stream_q.push_back(CHAR_START);
    stream_q.push_back(CHAR_START);
    stream_q.push_back(CHAR_V1);
    stream_q.push_back(DIR_RESET);
    add_frame(1'b0, DIR_RESET, 16'd0, 8'h00, 16'h00FF, 1'b0);
    add_frame(1'b1, DIR_RESET, 16'd1, 8'hFF, 16'hFFFF, 1'b1);
    stream_q.push_back(CHAR_START);
    stream_q.push_back(CHAR_V1);
    stream_q.push_back(8'h3C);
    add_frame(1'b1, DIR_RESET, 16'hFFFF, 8'h00, 16'h0000, 1'b0);
    send_stream();

    // Random frames under several direction settings.
    foreach (dir_plan[i]) begin
      wait_idle();
      write_direction(dir_plan[i]);
      gaps_on = (i % 2 == 0);
      run_random(RANDOM_ITEMS / 5);
      if (i == 2) begin
        // The receiver holds off while a long frame keeps coming.
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        add_frame(1'b1, sb.direction, 16'd40, 8'($urandom), 16'($urandom), 1'b0);
        send_stream();
      end
    end

    // Largest frames: full v1 size, one v2 length past the limit, and the v2
    // length at the limit, of which only the header and first payload bytes go out.
    wait_idle();
    gaps_on = 1'b0;
    add_frame(1'b0, sb.direction, 16'd255, 8'h00, 16'($urandom), 1'b0);
    add_frame(1'b1, sb.direction, 16'(MAX_FRAME) - 16'd8, 8'($urandom), 16'($urandom), 1'b0);
    add_frame(1'b1, sb.direction, 16'(MAX_FRAME) - 16'd9, 8'($urandom), 16'($urandom), 1'b0);
    repeat (MAX_FRAME - 16) void'(stream_q.pop_back());
    send_stream();

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
